// ===== src/izm_pkg.sv =====
// Shared types and constants of the 2x interpolating image zoom.
// Used by the front end, queue, back end and top module through scoped names.
package izm_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 9;
    localparam int LINE_PIXELS = 512;
    localparam int FRAME_ROWS  = 512;
    localparam int COL_W       = $clog2(LINE_PIXELS);
    localparam int ROW_W       = $clog2(FRAME_ROWS);
    localparam int OUT_COL_W   = 9;
    localparam int OUT_ROW_W   = 9;
    localparam int MAX_SPAN    = 256;
    localparam int SPAN_W      = $clog2(MAX_SPAN);
    localparam int CFG_IDX_W   = 2;
    localparam int FIFO_DEPTH  = 4;

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_PIXELS - 1);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(FRAME_ROWS - 1);
    localparam logic [CFG_W-1:0] SPAN_LIMIT = CFG_W'(MAX_SPAN);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 2'd3;

    localparam logic [CFG_W-1:0] RESET_WINDOW_LEFT   = 9'd128;
    localparam logic [CFG_W-1:0] RESET_WINDOW_WIDTH  = 9'd256;
    localparam logic [CFG_W-1:0] RESET_WINDOW_TOP    = 9'd128;
    localparam logic [CFG_W-1:0] RESET_WINDOW_HEIGHT = 9'd256;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_start;
        logic             frame_start;
    } src_word_t;

    typedef struct packed {
        logic [PIX_W-1:0]     out_pixel;
        logic [OUT_COL_W-1:0] out_column;
        logic [OUT_ROW_W-1:0] out_row;
        logic                 last;
    } dst_word_t;

    // One classified pixel of the window columns handed from the front to the back.
    typedef struct packed {
        logic              prime;
        logic [SPAN_W-1:0] idx;
        logic [SPAN_W-1:0] jrow;
        logic [PIX_W-1:0]  wide_a;
        logic [PIX_W-1:0]  wide_b;
    } job_t;

    typedef struct packed {
        logic valid;
        logic full;
    } fifo_status_t;

    function automatic logic [PIX_W-1:0] mean8(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        logic [PIX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[PIX_W:1];
    endfunction

endpackage

// ===== src/izm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first: a read and write of the same address return the old word.
module izm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/izm_front.sv =====
// Front end: window registers, source position counters and widening.
// Classifies each source word and hands window pixels on as jobs. Uses izm_pkg.
module izm_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [izm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [izm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           accept,
    input  izm_pkg::src_word_t             word,
    output logic                           push,
    output izm_pkg::job_t                  job
);

    logic [izm_pkg::CFG_W-1:0] window_left_reg;
    logic [izm_pkg::CFG_W-1:0] window_width_reg;
    logic [izm_pkg::CFG_W-1:0] window_top_reg;
    logic [izm_pkg::CFG_W-1:0] window_height_reg;

    logic [izm_pkg::COL_W-1:0] col_reg, col_next;
    logic [izm_pkg::ROW_W-1:0] row_reg, row_next;
    logic [izm_pkg::PIX_W-1:0] left_reg;

    logic [izm_pkg::CFG_W-1:0] width_eff, height_eff;
    logic [izm_pkg::CFG_W:0]   col_end, row_end;
    logic                      in_cols, in_rows, prime;
    logic [izm_pkg::CFG_W-1:0] col_off, row_off;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_left_reg   <= izm_pkg::RESET_WINDOW_LEFT;
            window_width_reg  <= izm_pkg::RESET_WINDOW_WIDTH;
            window_top_reg    <= izm_pkg::RESET_WINDOW_TOP;
            window_height_reg <= izm_pkg::RESET_WINDOW_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                izm_pkg::CFG_WINDOW_LEFT:   window_left_reg   <= cfg_data;
                izm_pkg::CFG_WINDOW_WIDTH:  window_width_reg  <= cfg_data;
                izm_pkg::CFG_WINDOW_TOP:    window_top_reg    <= cfg_data;
                izm_pkg::CFG_WINDOW_HEIGHT: window_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A frame mark overrides a row mark; counters saturate at the image edge.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (word.frame_start)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (word.row_start)
        begin
            col_next = '0;
            if (row_reg < izm_pkg::ROW_MAX)
            begin
                row_next = row_reg + 1'b1;
            end
        end
        else if (col_reg < izm_pkg::COL_MAX)
        begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= word.pixel;
        end
    end

    assign width_eff  = (window_width_reg > izm_pkg::SPAN_LIMIT) ? izm_pkg::SPAN_LIMIT
                                                                 : window_width_reg;
    assign height_eff = (window_height_reg > izm_pkg::SPAN_LIMIT) ? izm_pkg::SPAN_LIMIT
                                                                  : window_height_reg;
    assign col_end = {1'b0, window_left_reg} + {1'b0, width_eff};
    assign row_end = {1'b0, window_top_reg} + {1'b0, height_eff};

    assign in_cols = (col_next >= window_left_reg) && ({1'b0, col_next} < col_end);
    assign in_rows = (row_next >= window_top_reg) && ({1'b0, row_next} < row_end);
    // The row just above the window only fills the row store.
    assign prime   = (window_top_reg != '0) && (row_next == window_top_reg - 1'b1);

    assign col_off = col_next - window_left_reg;
    assign row_off = row_next - window_top_reg;

    assign push = accept && in_cols && (prime || in_rows);

    always_comb
    begin
        job.prime  = prime;
        job.idx    = col_off[izm_pkg::SPAN_W-1:0];
        job.jrow   = row_off[izm_pkg::SPAN_W-1:0];
        job.wide_a = izm_pkg::mean8(left_reg, word.pixel);
        job.wide_b = word.pixel;
    end

endmodule

// ===== src/izm_fifo.sv =====
// Short job queue between the front end and the back end.
// Holds izm_pkg::job_t entries; reports valid and full as one status struct.
module izm_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  izm_pkg::job_t          push_job,
    input  logic                   pop,
    output izm_pkg::job_t          head,
    output izm_pkg::fifo_status_t  status
);

    localparam int PTR_W = $clog2(izm_pkg::FIFO_DEPTH);

    izm_pkg::job_t      entry_reg [izm_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;
    logic               do_push, do_pop;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == (PTR_W+1)'(izm_pkg::FIFO_DEPTH));
    assign do_push = push && !status.full;
    assign do_pop  = pop && status.valid;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/izm_back.sv =====
// Back end: row store access and emission of four results per window pixel.
// Depends on izm_pkg and izm_ram; drives the output register of the block.
module izm_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  izm_pkg::job_t          head,
    input  izm_pkg::fifo_status_t  status,
    output logic                   pop,
    output logic                   dst_valid,
    input  logic                   dst_stall,
    output izm_pkg::dst_word_t     dst_data
);

    localparam int STORE_W = 2 * izm_pkg::PIX_W;

    logic                       busy_reg;
    logic [1:0]                 phase_reg;
    izm_pkg::job_t              job_reg;
    logic [STORE_W-1:0]         prev_pair;
    logic                       out_valid_reg;
    izm_pkg::dst_word_t         out_reg, result;
    logic                       advance, finishing;

    // The row store keeps one widened pixel pair per window column. Each job reads
    // the pair of the row above and overwrites it with its own in the same cycle.
    izm_ram #(
        .WIDTH(STORE_W),
        .DEPTH(izm_pkg::MAX_SPAN)
    ) u_row_store (
        .clk  (clk),
        .we   (pop),
        .waddr(head.idx),
        .wdata({head.wide_a, head.wide_b}),
        .re   (pop),
        .raddr(head.idx),
        .rdata(prev_pair)
    );

    assign advance   = busy_reg && (!out_valid_reg || !dst_stall);
    assign finishing = advance && (phase_reg == 2'd3);
    assign pop       = status.valid && (!busy_reg || finishing);

    always_comb
    begin
        result.out_column = {job_reg.idx, phase_reg[0]};
        result.out_row    = {job_reg.jrow, phase_reg[1]};
        result.last       = (phase_reg == 2'd3);
        case (phase_reg)
            2'd0:    result.out_pixel = izm_pkg::mean8(prev_pair[STORE_W-1:izm_pkg::PIX_W],
                                                       job_reg.wide_a);
            2'd1:    result.out_pixel = izm_pkg::mean8(prev_pair[izm_pkg::PIX_W-1:0],
                                                       job_reg.wide_b);
            2'd2:    result.out_pixel = job_reg.wide_a;
            default: result.out_pixel = job_reg.wide_b;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg  <= !head.prime;
                phase_reg <= '0;
            end
            else if (advance)
            begin
                phase_reg <= phase_reg + 1'b1;
                if (finishing)
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!dst_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

endmodule

// ===== src/image_zoom_2x_interpolating_unit.sv =====
// Two-times interpolating zoom of a configured window of an 8-bit grey image.
// Each window pixel is queued, then taken into the job register while the row store
// is read, and its four results leave in turn through the single output register.
// The queue takes new source words meanwhile until full; other words give no result.
// Reset clears the position counters, left neighbour and queue and loads the
// window registers with 128, 256, 128, 256; the row store is not cleared.
module image_zoom_2x_interpolating_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [izm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [izm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           src_valid,
    output logic                           src_stall,
    input  izm_pkg::src_word_t             src_data,
    output logic                           dst_valid,
    input  logic                           dst_stall,
    output izm_pkg::dst_word_t             dst_data
);

    logic                   accept, push, pop;
    izm_pkg::job_t          push_job, head;
    izm_pkg::fifo_status_t  status;

    assign src_stall = status.full;
    assign accept    = src_valid && !src_stall;

    izm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .accept   (accept),
        .word     (src_data),
        .push     (push),
        .job      (push_job)
    );

    izm_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head    (head),
        .status  (status)
    );

    izm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .status   (status),
        .pop      (pop),
        .dst_valid(dst_valid),
        .dst_stall(dst_stall),
        .dst_data (dst_data)
    );

endmodule

// ===== sim/tb_image_zoom_2x_interpolating_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the 2x interpolating image zoom.
// Holds its own predictor of the enlarged words; needs only izm_pkg and the unit.
module tb_image_zoom_2x_interpolating_unit;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS     = 90;
    localparam int MAX_WAIT         = 11;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [izm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [izm_pkg::CFG_W-1:0]      cfg_data = '0;
    logic                           src_valid = 1'b0;
    logic                           src_stall;
    izm_pkg::src_word_t             src_data = '0;
    logic                           dst_valid;
    logic                           dst_stall = 1'b0;
    izm_pkg::dst_word_t             dst_data;

    // Source words still to be offered and enlarged words still due.
    izm_pkg::src_word_t source_words[$];
    izm_pkg::dst_word_t enlarged_due[$];
    int        words_queued = 0;
    int        words_taken = 0;
    int        failures = 0;
    int        cycle_count = 0;

    logic      src_fire = 1'b0;
    logic      dst_fire = 1'b0;
    int        src_gap = 0;
    int        src_burst = 0;
    int        dst_gap = 0;
    int        dst_burst = 0;
    int        long_hold = 0;
    int        hold_requests = 0;
    int        holds_granted = 0;
    izm_pkg::dst_word_t due_word;

    // Predictor state: window registers as written, positions and row store.
    logic [izm_pkg::CFG_W-1:0] win_left = izm_pkg::RESET_WINDOW_LEFT;
    logic [izm_pkg::CFG_W-1:0] win_width = izm_pkg::RESET_WINDOW_WIDTH;
    logic [izm_pkg::CFG_W-1:0] win_top = izm_pkg::RESET_WINDOW_TOP;
    logic [izm_pkg::CFG_W-1:0] win_height = izm_pkg::RESET_WINDOW_HEIGHT;
    logic [izm_pkg::COL_W-1:0] cur_col = '0;
    logic [izm_pkg::ROW_W-1:0] cur_row = '0;
    logic [izm_pkg::PIX_W-1:0] left_pixel = '0;
    logic [izm_pkg::PIX_W-1:0] wide_store [0:izm_pkg::LINE_PIXELS-1];

    image_zoom_2x_interpolating_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [izm_pkg::PIX_W-1:0] floor_mean(
        input logic [izm_pkg::PIX_W-1:0] a,
        input logic [izm_pkg::PIX_W-1:0] b);
        return izm_pkg::PIX_W'((int'(a) + int'(b)) / 2);
    endfunction

    function automatic izm_pkg::dst_word_t enlarged_word(
        input logic [izm_pkg::PIX_W-1:0] px,
        input logic [izm_pkg::OUT_COL_W-1:0] col,
        input int rw, input logic fin);
        izm_pkg::dst_word_t w;
        w.out_pixel  = px;
        w.out_column = col;
        w.out_row    = izm_pkg::OUT_ROW_W'(rw);
        w.last       = fin;
        return w;
    endfunction

    // Works out the enlarged words that one accepted source word causes.
    task automatic predict_enlarged(input izm_pkg::src_word_t w);
        int                             span_w;
        int                             span_h;
        int                             j;
        logic [izm_pkg::OUT_COL_W-1:0]  k;
        logic [izm_pkg::OUT_COL_W-1:0]  k1;
        logic [izm_pkg::PIX_W-1:0]      wa;
        logic [izm_pkg::PIX_W-1:0]      wb;
        span_w = (win_width > izm_pkg::SPAN_LIMIT) ? izm_pkg::MAX_SPAN : int'(win_width);
        span_h = (win_height > izm_pkg::SPAN_LIMIT) ? izm_pkg::MAX_SPAN : int'(win_height);
        if (w.frame_start)
        begin
            cur_col = '0;
            cur_row = '0;
        end
        else if (w.row_start)
        begin
            cur_col = '0;
            if (cur_row < izm_pkg::ROW_MAX)
                cur_row = cur_row + 1'b1;
        end
        else if (cur_col < izm_pkg::COL_MAX)
        begin
            cur_col = cur_col + 1'b1;
        end
        wa = floor_mean(left_pixel, w.pixel);
        wb = w.pixel;
        left_pixel = w.pixel;
        if (int'(cur_col) < int'(win_left) || int'(cur_col) >= int'(win_left) + span_w)
            return;
        k  = izm_pkg::OUT_COL_W'(2 * (int'(cur_col) - int'(win_left)));
        k1 = k + 1'b1;
        // The row just above the window only loads the row store.
        if (win_top != 0 && int'(cur_row) + 1 == int'(win_top))
        begin
            wide_store[k]  = wa;
            wide_store[k1] = wb;
            return;
        end
        if (int'(cur_row) < int'(win_top) || int'(cur_row) >= int'(win_top) + span_h)
            return;
        j = int'(cur_row) - int'(win_top);
        enlarged_due.push_back(enlarged_word(floor_mean(wide_store[k], wa), k, 2 * j, 1'b0));
        enlarged_due.push_back(enlarged_word(floor_mean(wide_store[k1], wb), k1, 2 * j, 1'b0));
        enlarged_due.push_back(enlarged_word(wa, k, 2 * j + 1, 1'b0));
        enlarged_due.push_back(enlarged_word(wb, k1, 2 * j + 1, 1'b1));
        wide_store[k]  = wa;
        wide_store[k1] = wb;
    endtask

    always @(posedge clk)
    begin
        src_fire <= src_valid && !src_stall;
    end

    // Sender: offers queued source words, with random gaps and gap-free bursts.
    always @(negedge clk)
    begin
        if (src_fire)
        begin
            predict_enlarged(src_data);
            words_taken++;
            if (src_burst > 0)
            begin
                src_burst--;
                src_gap = 0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                src_burst = $urandom_range(8, 40);
                src_gap = 0;
            end
            else
            begin
                src_gap = $urandom_range(0, MAX_WAIT);
            end
        end
        // A stalled word stays on the bus unchanged.
        if (!src_valid || src_fire)
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                src_valid <= 1'b0;
            end
            else if (source_words.size() != 0)
            begin
                src_data <= source_words.pop_front();
                src_valid <= 1'b1;
            end
            else
            begin
                src_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls after each word for a random count, with gap-free bursts, or for one long stretch.
    always @(negedge clk)
    begin
        if (hold_requests != holds_granted)
        begin
            holds_granted++;
            long_hold = LONG_HOLD_CYCLES;
        end
        if (dst_fire)
        begin
            if (dst_burst > 0)
            begin
                dst_burst--;
                dst_gap = 0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                dst_burst = $urandom_range(8, 40);
                dst_gap = 0;
            end
            else
            begin
                dst_gap = $urandom_range(0, MAX_WAIT);
            end
        end
        if (long_hold > 0)
        begin
            long_hold--;
            dst_stall <= 1'b1;
        end
        else if (dst_gap > 0)
        begin
            dst_gap--;
            dst_stall <= 1'b1;
        end
        else
        begin
            dst_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        dst_fire <= rst_n && dst_valid && !dst_stall;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (enlarged_due.size() == 0)
            begin
                $error("unexpected enlarged word: pixel %0d column %0d row %0d",
                       dst_data.out_pixel, dst_data.out_column, dst_data.out_row);
                failures++;
            end
            else
            begin
                due_word = enlarged_due.pop_front();
                if (dst_data.out_pixel !== due_word.out_pixel)
                begin
                    $error("out_pixel: expected %0d, got %0d",
                           due_word.out_pixel, dst_data.out_pixel);
                    failures++;
                end
                if (dst_data.out_column !== due_word.out_column)
                begin
                    $error("out_column: expected %0d, got %0d",
                           due_word.out_column, dst_data.out_column);
                    failures++;
                end
                if (dst_data.out_row !== due_word.out_row)
                begin
                    $error("out_row: expected %0d, got %0d",
                           due_word.out_row, dst_data.out_row);
                    failures++;
                end
                if (dst_data.last !== due_word.last)
                begin
                    $error("last: expected %0d, got %0d", due_word.last, dst_data.last);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_image_zoom_2x_interpolating_unit failed");
            $finish;
        end
    end

    task automatic push_word(input logic [izm_pkg::PIX_W-1:0] px, input logic rs,
                             input logic fs);
        izm_pkg::src_word_t w;
        w.pixel       = px;
        w.row_start   = rs;
        w.frame_start = fs;
        source_words.push_back(w);
        words_queued++;
    endtask

    // Raster frame of random pixels; when noisy, some words are dropped or remarked.
    task automatic push_frame(input int rows, input int cols, input bit noisy);
        logic rs;
        logic fs;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                fs = (r == 0 && c == 0);
                rs = (r != 0 && c == 0);
                if (noisy && $urandom_range(0, 15) == 0)
                    continue;
                if (noisy && $urandom_range(0, 15) == 0)
                    {rs, fs} = 2'($urandom_range(0, 3));
                push_word(izm_pkg::PIX_W'($urandom_range(0, 255)), rs, fs);
            end
        end
    endtask

    // Waits until every word is taken and every enlarged word has come back.
    task automatic settle();
        while (words_taken != words_queued || enlarged_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [izm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [izm_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            izm_pkg::CFG_WINDOW_LEFT:   win_left = val;
            izm_pkg::CFG_WINDOW_WIDTH:  win_width = val;
            izm_pkg::CFG_WINDOW_TOP:    win_top = val;
            izm_pkg::CFG_WINDOW_HEIGHT: win_height = val;
            default: ;
        endcase
    endtask

    task automatic set_window(input int left, input int width, input int top,
                              input int height);
        settle();
        cfg_write(izm_pkg::CFG_WINDOW_LEFT, izm_pkg::CFG_W'(left));
        cfg_write(izm_pkg::CFG_WINDOW_WIDTH, izm_pkg::CFG_W'(width));
        cfg_write(izm_pkg::CFG_WINDOW_TOP, izm_pkg::CFG_W'(top));
        cfg_write(izm_pkg::CFG_WINDOW_HEIGHT, izm_pkg::CFG_W'(height));
    endtask

    function automatic int pick_span();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return $urandom_range(izm_pkg::MAX_SPAN + 1, 511);
        return $urandom_range(1, 5);
    endfunction

    initial
    begin
        int first_word;
        int left;
        int width;
        int top;
        int height;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // The first word after reset, unmarked, lands on column 1 of row 0 and
        // primes; its left neighbour is zero.
        set_window(1, 3, 1, 2);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'h01, 1'b0, 1'b0);
        push_word(8'hFE, 1'b0, 1'b0);
        push_word(8'h80, 1'b1, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'h55, 1'b1, 1'b0);
        push_word(8'hAA, 1'b0, 1'b0);
        push_word(8'h7F, 1'b0, 1'b0);
        push_word(8'h80, 1'b0, 1'b0);
        push_word(8'h12, 1'b1, 1'b0);
        push_word(8'h34, 1'b0, 1'b0);
        // A frame mark wins over a row mark on the same word.
        push_word(8'hC3, 1'b1, 1'b1);
        push_word(8'h3C, 1'b0, 1'b0);
        push_word(8'hFF, 1'b1, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);

        // Empty windows: zero width, then zero height.
        set_window(1, 0, 1, 2);
        push_frame(2, 3, 1'b0);
        set_window(1, 2, 1, 0);
        push_frame(2, 3, 1'b0);

        // An oversized width covers every column from 1 on and fills the first row store
        // entries. The receiver holds off at the start so the unit backs up.
        set_window(1, 300, 1, 1);
        hold_requests++;
        push_frame(2, 12, 1'b0);

        // Zero left: each row's first left neighbour comes from the row before.
        set_window(0, 2, 1, 2);
        push_frame(3, 3, 1'b0);

        // Zero top: row 0 averages with what the row store already holds.
        set_window(2, 3, 0, 2);
        push_frame(2, 6, 1'b0);

        // Random windows with frames in which some words are dropped or remarked.
        first_word = words_queued;
        while (words_queued - first_word < RANDOM_WORDS)
        begin
            left   = $urandom_range(0, 5);
            width  = pick_span();
            top    = $urandom_range(0, 3);
            height = pick_span();
            set_window(left, width, top, height);
            repeat ($urandom_range(1, 2))
                push_frame(top + (height > 3 ? 3 : height) + $urandom_range(1, 2),
                           left + (width > 5 ? 5 : width) + $urandom_range(1, 2), 1'b1);
        end

        settle();
        if (failures == 0)
        begin
            $display("tb_image_zoom_2x_interpolating_unit passed");
        end
        else
        begin
            $display("tb_image_zoom_2x_interpolating_unit failed");
        end
        $finish;
    end

endmodule
